/* hw/rtl/rabgs_pkg.sv */
// Shared constants for the running-average background subtractor.
`timescale 1ns / 1ps
package rabgs_pkg;

    typedef enum logic [1:0] {
        REG_THRESHOLD    = 2'd0,
        REG_ACCUM_FRAMES = 2'd1,
        REG_FRAME_PIXELS = 2'd2
    } reg_index_t;

    localparam int unsigned GRAY_W_BLUE  = 1868;
    localparam int unsigned GRAY_W_GREEN = 9617;
    localparam int unsigned GRAY_W_RED   = 4899;
    localparam int unsigned GRAY_ROUND   = 8192;
    localparam int unsigned GRAY_SHIFT   = 14;

    localparam logic [7:0]  THRESHOLD_RESET    = 8'd30;
    localparam logic [7:0]  ACCUM_FRAMES_RESET = 8'd32;
    localparam logic [19:0] FRAME_PIXELS_RESET = 20'd307200;

endpackage

/* hw/rtl/rabgs_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module rabgs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* hw/rtl/running_average_background_subtractor.sv */
// Top level of the running-average background subtractor.
// Usage:
//   s_axis carries one BGR pixel per request in raster order; m_axis returns one
//   result per pixel: foreground bit, 8-bit background, and tlast on the last
//   pixel of a frame. The cfg port writes threshold, warm-up frame count and
//   frame size; the user must write them only while the block is idle (not enforced).
//   The per-pixel model lives in one RAM, read at accept and written back once
//   the averaging divide completes; a second divide forms the warm-up mean.
//   Each divide is a restoring divider with one quotient bit per stage.
//   Throughput: one pixel per cycle while m_axis is not stalled and frame_pixels
//   exceeds (16+MODEL_FRACTION_BITS)+4; smaller frames admit a pixel only once the
//   read-modify-write section is empty.
//   Reset clears the pixel position and warm-up progress and loads register
//   defaults; model RAM contents are not cleared (first warm-up frame ignores them).
//   When m_axis stalls the whole pipeline holds and s_axis_tready drops.
`timescale 1ns / 1ps
module running_average_background_subtractor
    import rabgs_pkg::*;
#(
    parameter int MAX_PIXELS          = 524288,
    parameter int MODEL_FRACTION_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [19:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // blue[7:0], green[15:8], red[23:16]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // foreground[0], background[8:1], zero[15:9]
    output logic        m_axis_tlast
);

    localparam int F   = MODEL_FRACTION_BITS;
    localparam int MW  = 8 + F;
    localparam int DW  = MW + 8;
    localparam int AW  = $clog2(MAX_PIXELS);
    localparam int FPW = (AW + 1 > 21) ? AW + 1 : 21;
    localparam int NS  = 2 * DW + 6;
    localparam int ST_S1  = 1;
    localparam int ST_SA1 = DW + 2;
    localparam int ST_SA2 = DW + 3;
    localparam int ST_D   = 2 * DW + 4;
    localparam logic [FPW-1:0] FP_MAX  = FPW'(MAX_PIXELS);
    localparam logic [FPW-1:0] FP_FAST = FPW'(DW + 4);
    localparam logic [DW-1:0]  HALF_D  = DW'(1) << (F - 1);

    typedef struct packed {
        logic [AW-1:0] idx;
        logic [7:0]    gray;
        logic          warm;
        logic          first;
        logic          last;
        logic [7:0]    n;
        logic [7:0]    cnt;
        logic [7:0]    dv;
        logic [MW-1:0] model;
        logic [7:0]    rem;
        logic [DW-1:0] num;
        logic          fg;
        logic [7:0]    bg;
    } stage_t;

    logic [7:0]    threshold_reg, threshold_next;
    logic [7:0]    accum_frames_reg, accum_frames_next;
    logic [19:0]   frame_pixels_reg, frame_pixels_next;
    logic [AW-1:0] pixel_index_reg, pixel_index_next;
    logic [7:0]    warmup_count_reg, warmup_count_next;
    logic          warmed_up_reg, warmed_up_next;
    logic [NS-1:0] valid_reg, valid_next;
    stage_t        pipe_reg [NS];
    stage_t        pipe_next [NS];

    logic           adv;
    logic           accept;
    logic           busy;
    logic [7:0]     n_eff;
    logic [FPW-1:0] fp_ext;
    logic [FPW-1:0] fp_eff;
    logic           last_now;
    logic [8:0]     count_now;
    logic [21:0]    gray_sum;
    logic [MW-1:0]  rd_data;

    assign adv   = !valid_reg[NS-1] || m_axis_tready;
    assign busy  = |valid_reg[ST_SA1:0];
    assign n_eff = (accum_frames_reg == 8'd0) ? 8'd1 : accum_frames_reg;

    always_comb
    begin
        fp_ext = FPW'(frame_pixels_reg);
        if (fp_ext == '0)
        begin
            fp_eff = FPW'(1);
        end
        else if (fp_ext > FP_MAX)
        begin
            fp_eff = FP_MAX;
        end
        else
        begin
            fp_eff = fp_ext;
        end
    end

    assign s_axis_tready = adv && ((fp_eff > FP_FAST) || !busy);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign last_now      = (FPW'(pixel_index_reg) + FPW'(1)) >= fp_eff;
    assign count_now     = {1'b0, warmup_count_reg} + 9'd1;

    assign gray_sum = 22'(GRAY_W_BLUE) * 22'(s_axis_tdata[7:0])
                    + 22'(GRAY_W_GREEN) * 22'(s_axis_tdata[15:8])
                    + 22'(GRAY_W_RED) * 22'(s_axis_tdata[23:16])
                    + 22'(GRAY_ROUND);

    always_comb
    begin
        threshold_next    = threshold_reg;
        accum_frames_next = accum_frames_reg;
        frame_pixels_next = frame_pixels_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_THRESHOLD:    threshold_next    = cfg_data[7:0];
                REG_ACCUM_FRAMES: accum_frames_next = cfg_data[7:0];
                REG_FRAME_PIXELS: frame_pixels_next = cfg_data;
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        pixel_index_next  = pixel_index_reg;
        warmup_count_next = warmup_count_reg;
        warmed_up_next    = warmed_up_reg;
        if (accept)
        begin
            if (last_now)
            begin
                pixel_index_next = '0;
                if (!warmed_up_reg)
                begin
                    if (warmup_count_reg != 8'd255)
                    begin
                        warmup_count_next = warmup_count_reg + 8'd1;
                    end
                    if (count_now >= {1'b0, n_eff})
                    begin
                        warmed_up_next = 1'b1;
                    end
                end
            end
            else
            begin
                pixel_index_next = pixel_index_reg + AW'(1);
            end
        end
    end

    always_comb
    begin
        stage_t          prv;
        stage_t          nx;
        logic [8:0]      t;
        logic            ge;
        logic [MW-1:0]   mdl;
        logic [DW-1:0]   gray_f;
        logic [DW:0]     sum;
        logic [DW-1:0]   dif;
        logic [DW-F:0]   rnd;
        logic [7:0]      rs;
        logic [MW:0]     by_sum;
        logic [MW-F:0]   by;

        nx       = '0;
        nx.idx   = pixel_index_reg;
        nx.gray  = gray_sum[21:14];
        nx.warm  = !warmed_up_reg;
        nx.first = (warmup_count_reg == 8'd0);
        nx.last  = last_now;
        nx.n     = n_eff;
        nx.cnt   = count_now[7:0];
        pipe_next[0] = nx;

        for (int k = 1; k < NS; k++)
        begin
            t      = '0;
            ge     = 1'b0;
            mdl    = '0;
            sum    = '0;
            dif    = '0;
            rnd    = '0;
            rs     = '0;
            by_sum = '0;
            by     = '0;
            prv    = pipe_reg[k-1];
            nx     = prv;
            gray_f = DW'(prv.gray) << F;
            if (k == ST_S1)
            begin
                mdl      = prv.first ? '0 : rd_data;
                nx.model = mdl;
                nx.rem   = '0;
                nx.dv    = prv.n;
                if (prv.warm)
                begin
                    nx.num = gray_f + DW'(prv.n >> 1);
                end
                else
                begin
                    nx.num = DW'(mdl) * DW'(prv.n - 8'd1) + gray_f + DW'(prv.n >> 1);
                end
            end
            else if ((k < ST_SA1) || ((k > ST_SA2) && (k < ST_D)))
            begin
                t      = {prv.rem, prv.num[DW-1]};
                ge     = t >= {1'b0, prv.dv};
                nx.rem = ge ? 8'(t - {1'b0, prv.dv}) : t[7:0];
                nx.num = {prv.num[DW-2:0], ge};
            end
            else if (k == ST_SA1)
            begin
                sum = prv.warm ? (DW+1)'(prv.model) + (DW+1)'(prv.num)
                               : (DW+1)'(prv.num);
                nx.model = (sum[DW:MW] != '0) ? '1 : sum[MW-1:0];
            end
            else if (k == ST_SA2)
            begin
                nx.rem = '0;
                if (prv.warm)
                begin
                    nx.num = DW'(prv.model) * DW'(prv.n) + DW'(prv.cnt >> 1);
                    nx.dv  = prv.cnt;
                end
                else
                begin
                    nx.num = DW'(prv.model);
                    nx.dv  = 8'd1;
                end
            end
            else if (k == ST_D)
            begin
                dif    = (gray_f > prv.num) ? gray_f - prv.num : prv.num - gray_f;
                rnd    = (DW-F+1)'(((DW+1)'(dif) + (DW+1)'(HALF_D)) >> F);
                rs     = (rnd > (DW-F+1)'(255)) ? 8'd255 : rnd[7:0];
                nx.fg  = rs > threshold_reg;
                by_sum = (MW+1)'(prv.model) + (MW+1)'(HALF_D);
                by     = by_sum[MW:F];
                if (prv.warm)
                begin
                    nx.bg = 8'd0;
                end
                else
                begin
                    nx.bg = (by > (MW-F+1)'(255)) ? 8'd255 : by[7:0];
                end
            end
            pipe_next[k] = nx;
        end
    end

    assign valid_next = {valid_reg[NS-2:0], accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg    <= THRESHOLD_RESET;
            accum_frames_reg <= ACCUM_FRAMES_RESET;
            frame_pixels_reg <= FRAME_PIXELS_RESET;
            pixel_index_reg  <= '0;
            warmup_count_reg <= '0;
            warmed_up_reg    <= 1'b0;
            valid_reg        <= '0;
        end
        else
        begin
            threshold_reg    <= threshold_next;
            accum_frames_reg <= accum_frames_next;
            frame_pixels_reg <= frame_pixels_next;
            pixel_index_reg  <= pixel_index_next;
            warmup_count_reg <= warmup_count_next;
            warmed_up_reg    <= warmed_up_next;
            if (adv)
            begin
                valid_reg <= valid_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < NS; k++)
            begin
                pipe_reg[k] <= pipe_next[k];
            end
        end
    end

    rabgs_ram #(
        .WIDTH (MW),
        .DEPTH (MAX_PIXELS)
    ) u_model_ram (
        .clk     (clk),
        .wr_en   (valid_reg[ST_SA1]),
        .wr_addr (pipe_reg[ST_SA1].idx),
        .wr_data (pipe_reg[ST_SA1].model),
        .rd_en   (adv),
        .rd_addr (pixel_index_reg),
        .rd_data (rd_data)
    );

    assign m_axis_tvalid = valid_reg[NS-1];
    assign m_axis_tdata  = {7'd0, pipe_reg[NS-1].bg, pipe_reg[NS-1].fg};
    assign m_axis_tlast  = pipe_reg[NS-1].last;

endmodule

/* verif/rabgs_checker.sv */
// Checker for the background subtractor: predicts each result and compares it.
`timescale 1ns / 1ps
module rabgs_checker
    import rabgs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [19:0] cfg_data,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,
    input  logic        m_axis_tlast,
    output int          errors,
    output int          pending
);

    localparam int unsigned FRAC = 16;
    localparam longint unsigned PIX_LIMIT = 524288;
    localparam longint unsigned MODEL_TOP = (longint'(256) << FRAC) - 1;
    localparam longint unsigned HALF_STEP = longint'(1) << (FRAC - 1);

    typedef struct packed {
        logic       foreground;
        logic [7:0] background;
        logic       frame_end;
    } mask_result_t;

    mask_result_t    mask_q[$];
    logic [23:0]     model_mem[int unsigned];
    int unsigned     pix_pos;
    logic [7:0]      warm_frames;
    logic            warm_done;
    logic [7:0]      thr_reg;
    logic [7:0]      frames_reg;
    logic [19:0]     size_reg;

    function automatic longint unsigned clip_model(input longint unsigned v);
        return (v > MODEL_TOP) ? MODEL_TOP : v;
    endfunction

    function automatic longint unsigned gray_diff(input longint unsigned a,
                                                  input longint unsigned b);
        longint unsigned d;
        d = (a > b) ? a - b : b - a;
        d = (d + HALF_STEP) >> FRAC;
        return (d > 255) ? 255 : d;
    endfunction

    function automatic void predict_mask(input logic [23:0] px);
        longint unsigned gray, gray_f, n, fp, mdl, cnt, mean, diff, bgv, by;
        int unsigned     idx;
        logic            last_px;
        mask_result_t    res;
        gray = (GRAY_W_BLUE * longint'(px[7:0]) + GRAY_W_GREEN * longint'(px[15:8])
                + GRAY_W_RED * longint'(px[23:16]) + GRAY_ROUND) >> GRAY_SHIFT;
        gray_f = gray << FRAC;
        n = (frames_reg == 0) ? 1 : frames_reg;
        fp = (size_reg == 0) ? 1 : size_reg;
        if (fp > PIX_LIMIT)
            fp = PIX_LIMIT;
        idx = pix_pos % PIX_LIMIT;
        mdl = model_mem.exists(idx) ? model_mem[idx] : 0;
        bgv = 0;
        if (!warm_done)
        begin
            cnt = longint'(warm_frames) + 1;
            if (warm_frames == 0)
                mdl = 0;
            mdl = clip_model(mdl + (gray_f + n / 2) / n);
            mean = (mdl * n + cnt / 2) / cnt;
            diff = gray_diff(gray_f, mean);
        end
        else
        begin
            mdl = clip_model((mdl * (n - 1) + gray_f + n / 2) / n);
            by = (mdl + HALF_STEP) >> FRAC;
            bgv = (by > 255) ? 255 : by;
            diff = gray_diff(gray_f, mdl);
        end
        model_mem[idx] = mdl[23:0];
        last_px = (longint'(pix_pos) + 1 >= fp);
        if (last_px)
        begin
            pix_pos = 0;
            if (!warm_done)
            begin
                cnt = longint'(warm_frames) + 1;
                if (warm_frames < 255)
                    warm_frames = warm_frames + 1;
                if (cnt >= n)
                    warm_done = 1'b1;
            end
        end
        else
        begin
            pix_pos = pix_pos + 1;
        end
        res.foreground = (diff > thr_reg);
        res.background = bgv[7:0];
        res.frame_end = last_px;
        mask_q.push_back(res);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        mask_result_t exp_r;
        if (!rst_n)
        begin
            mask_q.delete();
            pix_pos = 0;
            warm_frames = 0;
            warm_done = 1'b0;
            thr_reg = THRESHOLD_RESET;
            frames_reg = ACCUM_FRAMES_RESET;
            size_reg = FRAME_PIXELS_RESET;
            errors = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (reg_index_t'(cfg_index))
                    REG_THRESHOLD:    thr_reg = cfg_data[7:0];
                    REG_ACCUM_FRAMES: frames_reg = cfg_data[7:0];
                    REG_FRAME_PIXELS: size_reg = cfg_data;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                predict_mask(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (mask_q.size() == 0)
                begin
                    $display("%0t: unexpected result tdata=%h tlast=%b",
                             $time, m_axis_tdata, m_axis_tlast);
                    errors = errors + 1;
                end
                else
                begin
                    exp_r = mask_q.pop_front();
                    if (m_axis_tdata[0] !== exp_r.foreground)
                    begin
                        $display("%0t: foreground expected %b actual %b",
                                 $time, exp_r.foreground, m_axis_tdata[0]);
                        errors = errors + 1;
                    end
                    if (m_axis_tdata[8:1] !== exp_r.background)
                    begin
                        $display("%0t: background expected %0d actual %0d",
                                 $time, exp_r.background, m_axis_tdata[8:1]);
                        errors = errors + 1;
                    end
                    if (m_axis_tlast !== exp_r.frame_end)
                    begin
                        $display("%0t: frame end expected %b actual %b",
                                 $time, exp_r.frame_end, m_axis_tlast);
                        errors = errors + 1;
                    end
                end
            end
            pending = mask_q.size();
        end
    end

endmodule

/* verif/tb_running_average_background_subtractor.sv */
// Testbench top for the background subtractor: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module tb_running_average_background_subtractor;
    import rabgs_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_CYCLES = 100;
    localparam int MODEL_COVER = 64;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [19:0] cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;
    int          errors;
    int          pending;
    int          cycle_count;
    int          pixels_sent;
    bit          sender_burst;
    bit          long_hold_req;
    logic [23:0] scene[MODEL_COVER];

    running_average_background_subtractor u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    rabgs_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .errors        (errors),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count = cycle_count + 1;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // receiver: short random stalls, quiet stretches, one long hold-off
    initial
    begin
        int hold;
        int mode_left;
        bit quiet;
        bit long_done;
        hold = 0;
        mode_left = 0;
        quiet = 0;
        long_done = 0;
        m_axis_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (mode_left == 0)
            begin
                quiet = ($urandom_range(0, 3) == 0);
                mode_left = $urandom_range(100, 600);
            end
            mode_left = mode_left - 1;
            if (long_hold_req && !long_done)
            begin
                long_done = 1;
                hold = 400;
            end
            if (hold > 0)
            begin
                m_axis_tready <= 1'b0;
                hold = hold - 1;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                hold = quiet ? 0 : $urandom_range(0, 5);
            end
        end
    end

    task automatic write_reg(input reg_index_t idx, input logic [19:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic send_pixel(input logic [23:0] px);
        int gap;
        bit ok;
        gap = sender_burst ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= px;
        do
        begin
            @(negedge clk);
            ok = s_axis_tready;
            @(posedge clk);
        end
        while (!ok);
        pixels_sent = pixels_sent + 1;
    endtask

    function automatic logic [23:0] scene_pixel(input int pos);
        logic [23:0] px;
        int k;
        px = scene[pos % MODEL_COVER];
        for (k = 0; k < 3; k++)
            px[k*8 +: 8] = px[k*8 +: 8] + 8'($urandom_range(0, 6)) - 8'd3;
        return px;
    endfunction

    task automatic send_random_pixel(input int pos);
        if ($urandom_range(0, 4) == 0)
            send_pixel(24'($urandom));
        else
            send_pixel(scene_pixel(pos));
    endtask

    initial
    begin
        int i;
        int count;
        int fsize;
        logic [23:0] first_frame[$];
        rst_n <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= REG_THRESHOLD;
        cfg_data <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        pixels_sent = 0;
        sender_burst = 0;
        long_hold_req = 0;
        for (i = 0; i < MODEL_COVER; i++)
            scene[i] = 24'($urandom);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // first warm-up frame writes every model entry used later
        write_reg(REG_THRESHOLD, 20'd0);
        write_reg(REG_ACCUM_FRAMES, 20'd255);
        write_reg(REG_FRAME_PIXELS, 20'(MODEL_COVER));
        first_frame = '{24'h000000, 24'hFFFFFF, 24'h0000FF, 24'h00FF00, 24'hFF0000,
                        24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'h808080, 24'h7F7F7F};
        for (i = 0; i < MODEL_COVER; i++)
            send_pixel((i < first_frame.size()) ? first_frame[i] : scene_pixel(i));

        // zero frame size acts as one pixel
        wait_drained();
        write_reg(REG_FRAME_PIXELS, 20'd0);
        for (i = 0; i < 200; i++)
            send_random_pixel(0);

        // largest and oversized frames, then shrink mid-frame
        wait_drained();
        write_reg(REG_FRAME_PIXELS, 20'd524288);
        for (i = 0; i < 10; i++)
            send_random_pixel(i);
        wait_drained();
        write_reg(REG_FRAME_PIXELS, 20'hFFFFF);
        for (i = 10; i < 20; i++)
            send_random_pixel(i);
        wait_drained();
        write_reg(REG_FRAME_PIXELS, 20'd4);
        send_random_pixel(20);

        // zero warm-up count acts as one: the next frame ends warm-up
        wait_drained();
        write_reg(REG_THRESHOLD, 20'd255);
        write_reg(REG_ACCUM_FRAMES, 20'd0);
        write_reg(REG_FRAME_PIXELS, 20'(MODEL_COVER));
        for (i = 0; i < 2 * MODEL_COVER; i++)
            send_random_pixel(i);

        while (pixels_sent < 1900)
        begin
            wait_drained();
            case ($urandom_range(0, 3))
                0: write_reg(REG_THRESHOLD, 20'd0);
                1: write_reg(REG_THRESHOLD, 20'd255);
                default: write_reg(REG_THRESHOLD, 20'($urandom_range(0, 40)));
            endcase
            case ($urandom_range(0, 5))
                0: write_reg(REG_ACCUM_FRAMES, 20'd0);
                1: write_reg(REG_ACCUM_FRAMES, 20'd1);
                2: write_reg(REG_ACCUM_FRAMES, 20'd255);
                default: write_reg(REG_ACCUM_FRAMES, 20'($urandom_range(2, 254)));
            endcase
            case ($urandom_range(0, 3))
                0: fsize = 1;
                1: fsize = MODEL_COVER;
                default: fsize = $urandom_range(1, MODEL_COVER);
            endcase
            write_reg(REG_FRAME_PIXELS, 20'(fsize));
            if ($urandom_range(0, 5) == 0)
                for (i = 0; i < MODEL_COVER; i++)
                    scene[i] = 24'($urandom);
            sender_burst = ($urandom_range(0, 3) == 0);
            count = $urandom_range(60, 150);
            for (i = 0; i < count; i++)
            begin
                if (pixels_sent >= 1000)
                    long_hold_req = 1;
                send_random_pixel(i % fsize);
            end
        end

        s_axis_tvalid <= 1'b0;
        i = 0;
        do
        begin
            @(negedge clk);
            i = i + 1;
        end
        while (pending != 0 && i < 100000);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
